@@ rtl/core/b64u_pkg.sv @@
// ----------------------------------------------------------------------------
// b64u_pkg
// Shared types, character codes and the symbol lookup for the Base64 and
// Base64url stream decoder.
// ----------------------------------------------------------------------------
package b64u_pkg;

  localparam int unsigned SymW  = 8;
  localparam int unsigned ByteW = 8;
  localparam int unsigned ValW  = 6;

  // Character codes of the two alphabets and the pad character.
  localparam logic [SymW-1:0] CharPad   = 8'h3D;  // '='
  localparam logic [SymW-1:0] CharPlus  = 8'h2B;  // '+'
  localparam logic [SymW-1:0] CharMinus = 8'h2D;  // '-'
  localparam logic [SymW-1:0] CharSlash = 8'h2F;  // '/'
  localparam logic [SymW-1:0] CharUnder = 8'h5F;  // '_'
  localparam logic [SymW-1:0] CharUpA   = 8'h41;  // 'A'
  localparam logic [SymW-1:0] CharUpZ   = 8'h5A;  // 'Z'
  localparam logic [SymW-1:0] CharLoA   = 8'h61;  // 'a'
  localparam logic [SymW-1:0] CharLoZ   = 8'h7A;  // 'z'
  localparam logic [SymW-1:0] CharDig0  = 8'h30;  // '0'
  localparam logic [SymW-1:0] CharDig9  = 8'h39;  // '9'

  // Value offsets of the lower-case letters and the digits.
  localparam logic [SymW-1:0] OffsLower = 8'd26;
  localparam logic [SymW-1:0] OffsDigit = 8'd52;
  localparam logic [ValW-1:0] ValDash   = 6'd62;
  localparam logic [ValW-1:0] ValSlash  = 6'd63;

  // Decoded symbol: six-bit value and a flag for a character outside both
  // alphabets (whose value then reads as zero).
  typedef struct packed {
    logic            bad;
    logic [ValW-1:0] val;
  } sym_t;

  // One result as it leaves the decoder.
  typedef struct packed {
    logic [ByteW-1:0] data_byte;
    logic             byte_valid;
    logic             done_res;
    logic             bad_input;
  } result_t;

  function automatic sym_t sym_lookup(input logic [SymW-1:0] c);
    sym_t            s;
    logic [SymW-1:0] t;
    s.bad = 1'b0;
    s.val = '0;
    t     = '0;
    if (c >= CharUpA && c <= CharUpZ) begin
      t     = c - CharUpA;
      s.val = t[ValW-1:0];
    end else if (c >= CharLoA && c <= CharLoZ) begin
      t     = c - CharLoA + OffsLower;
      s.val = t[ValW-1:0];
    end else if (c >= CharDig0 && c <= CharDig9) begin
      t     = c - CharDig0 + OffsDigit;
      s.val = t[ValW-1:0];
    end else if (c == CharPlus || c == CharMinus) begin
      s.val = ValDash;
    end else if (c == CharSlash || c == CharUnder) begin
      s.val = ValSlash;
    end else begin
      s.bad = 1'b1;
    end
    return s;
  endfunction

endpackage

@@ rtl/core/b64u_step.sv @@
// ----------------------------------------------------------------------------
// b64u_step
// Group state of the decoder and the combinational decode of one character.
// ----------------------------------------------------------------------------
module b64u_step (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     take_i,
  input  logic [b64u_pkg::SymW-1:0] symbol_i,
  input  logic                     final_char_i,
  output logic                     has_result_o,
  output b64u_pkg::result_t        result_o
);
  import b64u_pkg::*;

  logic [1:0]      pos_q, pos_d;
  logic [ValW-1:0] carry_q, carry_d;
  logic            pad_q, pad_d;
  logic            err_q, err_d;
  logic            lead_q, lead_d;
  sym_t            sym;
  logic [ByteW-1:0] byte_val;
  logic            byte_ok;

  assign sym = sym_lookup(symbol_i);

  always_comb begin
    pos_d    = pos_q;
    carry_d  = carry_q;
    pad_d    = pad_q;
    err_d    = err_q;
    lead_d   = lead_q;
    byte_val = '0;
    byte_ok  = 1'b0;
    if (symbol_i == CharPad) begin
      pad_d = 1'b1;
    end else if (pad_q) begin
      // Anything but padding after padding is malformed.
      err_d = 1'b1;
    end else if (pos_q == 2'd0) begin
      lead_d  = sym.bad;
      carry_d = sym.val;
      pos_d   = 2'd1;
    end else begin
      err_d  = err_q | sym.bad | ((pos_q == 2'd1) & lead_q);
      lead_d = 1'b0;
      case (pos_q)
        2'd1: begin
          byte_val = {carry_q, sym.val[5:4]};
          carry_d  = {2'b00, sym.val[3:0]};
        end
        2'd2: begin
          byte_val = {carry_q[3:0], sym.val[5:2]};
          carry_d  = {4'b0000, sym.val[1:0]};
        end
        default: begin
          byte_val = {carry_q[1:0], sym.val};
          carry_d  = '0;
        end
      endcase
      pos_d   = pos_q + 2'd1;
      byte_ok = ~err_d;
    end
  end

  assign has_result_o         = final_char_i | byte_ok;
  assign result_o.data_byte   = byte_ok ? byte_val : '0;
  assign result_o.byte_valid  = byte_ok;
  assign result_o.done_res    = final_char_i;
  assign result_o.bad_input   = final_char_i & err_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      carry_q <= '0;
      pad_q   <= 1'b0;
      err_q   <= 1'b0;
      lead_q  <= 1'b0;
    end else if (take_i) begin
      if (final_char_i) begin
        pos_q   <= '0;
        carry_q <= '0;
        pad_q   <= 1'b0;
        err_q   <= 1'b0;
        lead_q  <= 1'b0;
      end else begin
        pos_q   <= pos_d;
        carry_q <= carry_d;
        pad_q   <= pad_d;
        err_q   <= err_d;
        lead_q  <= lead_d;
      end
    end
  end

endmodule

@@ rtl/core/base64url_stream_decoder.sv @@
// Each result is registered, in the skid entry if the result register is held.
// Throughput: one character per cycle unless stalled; the loop through the group
// position and carried bits, updated once per accepted character, sets this figure.
// A two-entry output stage (result register and skid register) lets characters keep
// flowing while a result waits; input stalls only when both entries are full.
// Reset: asynchronous, active low; clears group state and empties the output stage.
// ----------------------------------------------------------------------------
// base64url_stream_decoder
// Streaming decoder for the Base64 and Base64url alphabets, one character per
// request, with a sticky error and a done result on the last character.
// ----------------------------------------------------------------------------
module base64url_stream_decoder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic [b64u_pkg::SymW-1:0]  symbol_i,
  input  logic                       final_char_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [b64u_pkg::ByteW-1:0] data_byte_o,
  output logic                       byte_valid_o,
  output logic                       done_res_o,
  output logic                       bad_input_o
);
  import b64u_pkg::*;

  // A request is taken whenever the skid entry is free. The skid entry is
  // only ever filled while the result register is held, so a free skid entry
  // always leaves room for one more result.
  logic    take;
  logic    has_result;
  result_t new_res;

  logic    out_valid_q, out_valid_d;
  result_t out_res_q, out_res_d;
  logic    skid_valid_q, skid_valid_d;
  result_t skid_res_q, skid_res_d;
  logic    out_fire;
  logic    out_free;

  assign in_ready_o = ~skid_valid_q;
  assign take       = in_valid_i & in_ready_o;

  b64u_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .symbol_i     (symbol_i),
    .final_char_i (final_char_i),
    .has_result_o (has_result),
    .result_o     (new_res)
  );

  assign out_fire = out_valid_q & out_ready_i;
  // The result register can load this cycle if it is empty or being drained.
  assign out_free = ~out_valid_q | out_fire;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_res_d    = out_res_q;
    skid_valid_d = skid_valid_q;
    skid_res_d   = skid_res_q;
    if (out_free) begin
      if (skid_valid_q) begin
        // Oldest result first: the skid entry moves forward.
        out_valid_d  = 1'b1;
        out_res_d    = skid_res_q;
        skid_valid_d = 1'b0;
      end else if (take && has_result) begin
        out_valid_d = 1'b1;
        out_res_d   = new_res;
      end else begin
        out_valid_d = 1'b0;
      end
    end else if (take && has_result) begin
      // Result register is held by the consumer; park the new result.
      skid_valid_d = 1'b1;
      skid_res_d   = new_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    out_res_q  <= out_res_d;
    skid_res_q <= skid_res_d;
  end

  assign out_valid_o  = out_valid_q;
  assign data_byte_o  = out_res_q.data_byte;
  assign byte_valid_o = out_res_q.byte_valid;
  assign done_res_o   = out_res_q.done_res;
  assign bad_input_o  = out_res_q.bad_input;

`ifndef SYNTHESIS
  // The skid entry is only occupied behind a full result register.
  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry holds a result while the result register is empty");

  // A shown result always carries a byte or ends the stream.
  a_result_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (byte_valid_o || done_res_o))
    else $error("empty result presented");

  // Error status is only reported with the done result.
  a_bad_with_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && bad_input_o) |-> done_res_o)
    else $error("bad_input without done_res");

  // A result without a byte shows a zero data field.
  a_zero_when_no_byte : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !byte_valid_o) |-> (data_byte_o == '0))
    else $error("data_byte not zero on a result without a byte");

  // The skid entry fills only while the result register was stalled.
  a_skid_fill_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_valid_q && !out_ready_i))
    else $error("skid entry filled while the result register could load");
`endif

endmodule
